// ===== rtl/core/trc_pkg.sv =====
// Package with the request and result types and constants of the traceroute reply classifier.
package trc_pkg;

  localparam logic [15:0] MIN_FRAME_LEN   = 16'd56;
  localparam int          TTL_FIELD_W     = 5;
  localparam logic [5:0]  MAX_HOPS        = 6'd32;
  localparam logic [7:0]  ICMP_UNREACH    = 8'd3;
  localparam logic [7:0]  ICMP_TIME_EXCD  = 8'd11;
  localparam logic [7:0]  UNREACH_CODE_LO = 8'd1;
  localparam logic [7:0]  UNREACH_CODE_HI = 8'd3;
  localparam logic [7:0]  TIME_EXCD_CODE  = 8'd0;
  localparam logic [31:0] CNT_MAX         = 32'hFFFF_FFFF;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECKSUM_OFFSET = 1'b0,
    CFG_TTL_OFFSET      = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_ABNORMAL = 2'd2,
    ST_RECORD   = 2'd3
  } status_t;

  typedef struct packed {
    logic        from_icmp_socket;
    logic [15:0] frame_length;
    logic [7:0]  reply_type;
    logic [7:0]  reply_code;
    logic [31:0] responder_addr;
    logic [31:0] quoted_dst_addr;
    logic [15:0] quoted_ip_id;
    logic [15:0] quoted_ip_len;
    logic [7:0]  quoted_ttl;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] target_addr;
    logic [31:0] hop_addr;
    logic [7:0]  hop_distance;
    logic        reached_target;
    logic [31:0] mismatch_total;
    logic [31:0] abnormal_total;
  } out_item_t;

endpackage

// ===== rtl/core/trc_if.sv =====
// Valid/ready channel interfaces for the reply requests and the classification results.
interface trc_in_if
  import trc_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trc_out_if
  import trc_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/traceroute_reply_classifier_core.sv =====
// Traceroute reply classifier: checks, classifies and counts one ICMP reply per request.
// An accepted request is held in the input register, and its result in the result register.
// Throughput is one request per cycle unless a result stalls; the input register and the
// result register are separated by a single pass of adds and compares.
// Reset is synchronous and active low; it clears the valid flags, both saturating
// counters and the two configuration registers.
module traceroute_reply_classifier_core
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  trc_in_if.sink                in_req,
  trc_out_if.source             out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] csum_off_r;
  logic [7:0]  ttl_off_r;
  logic [31:0] mism_cnt_r;
  logic [31:0] abn_cnt_r;

  logic        s2_load;
  out_item_t   res_nxt;
  logic [31:0] mism_cnt_nxt;
  logic [31:0] abn_cnt_nxt;

  logic [16:0] addr_sum;
  logic [15:0] addr_fold;
  logic [15:0] tag_raw;
  logic [15:0] tag;
  logic [5:0]  init_base;
  logic [8:0]  init_ttl;
  logic signed [10:0] hop_dist;
  logic signed [10:0] dist_lo;
  logic signed [10:0] dist_hi;
  logic        accepted;
  logic        is_unreach;
  logic        is_time_excd;

  assign s2_load      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s2_load;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  always_comb begin
    addr_sum  = {1'b0, s1_data_r.quoted_dst_addr[31:16]}
              + {1'b0, s1_data_r.quoted_dst_addr[15:0]};
    addr_fold = addr_sum[15:0] + {15'd0, addr_sum[16]};
    tag_raw   = ~addr_fold + csum_off_r;
    tag       = {tag_raw[7:0], tag_raw[15:8]};

    init_base = (s1_data_r.quoted_ip_len[TTL_FIELD_W-1:0] == '0) ? MAX_HOPS
              : {1'b0, s1_data_r.quoted_ip_len[TTL_FIELD_W-1:0]};
    init_ttl  = {3'd0, init_base} + {1'b0, ttl_off_r};

    accepted     = s1_data_r.from_icmp_socket && (s1_data_r.frame_length >= MIN_FRAME_LEN);
    is_unreach   = (s1_data_r.reply_type == ICMP_UNREACH)
                && (s1_data_r.reply_code >= UNREACH_CODE_LO)
                && (s1_data_r.reply_code <= UNREACH_CODE_HI);
    is_time_excd = (s1_data_r.reply_type == ICMP_TIME_EXCD)
                && (s1_data_r.reply_code == TIME_EXCD_CODE);

    if (is_unreach) begin
      hop_dist = $signed({2'd0, init_ttl}) - $signed({3'd0, s1_data_r.quoted_ttl}) + 11'sd1;
    end else begin
      hop_dist = $signed({2'd0, init_ttl});
    end
    dist_lo = $signed({3'd0, ttl_off_r});
    dist_hi = dist_lo + $signed({5'd0, MAX_HOPS});

    mism_cnt_nxt = mism_cnt_r;
    abn_cnt_nxt  = abn_cnt_r;
    res_nxt                = '0;
    res_nxt.status         = ST_IGNORED;

    if (accepted) begin
      if (tag != s1_data_r.quoted_ip_id) begin
        res_nxt.status = ST_MISMATCH;
        if (mism_cnt_r != CNT_MAX) begin
          mism_cnt_nxt = mism_cnt_r + 32'd1;
        end
      end else if (is_unreach || is_time_excd) begin
        if ((hop_dist <= dist_lo) || (hop_dist > dist_hi)) begin
          res_nxt.status = ST_ABNORMAL;
          if (abn_cnt_r != CNT_MAX) begin
            abn_cnt_nxt = abn_cnt_r + 32'd1;
          end
        end else begin
          res_nxt.status         = ST_RECORD;
          res_nxt.target_addr    = s1_data_r.quoted_dst_addr;
          res_nxt.hop_addr       = s1_data_r.responder_addr;
          res_nxt.hop_distance   = hop_dist[7:0];
          res_nxt.reached_target = is_unreach;
        end
      end
    end
    res_nxt.mismatch_total = mism_cnt_nxt;
    res_nxt.abnormal_total = abn_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      csum_off_r  <= '0;
      ttl_off_r   <= '0;
      mism_cnt_r  <= '0;
      abn_cnt_r   <= '0;
    end else begin
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
        mism_cnt_r  <= mism_cnt_nxt;
        abn_cnt_r   <= abn_cnt_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CHECKSUM_OFFSET: csum_off_r <= cfg_wdata[15:0];
          CFG_TTL_OFFSET:      ttl_off_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_data_r <= in_req.data;
    end
    if (s2_load) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/trc_checker.sv =====
// Port-level checker for the traceroute reply classifier, bound to the top level.
module trc_checker
  import trc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid directly after reset.");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was withdrawn.");

  a_non_record_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_RECORD) |->
      (out_data.target_addr == '0) && (out_data.hop_addr == '0) &&
      (out_data.hop_distance == '0) && !out_data.reached_target)
    else $error("Record fields set on a result that is not a record.");

  a_counts_follow_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_MISMATCH || out_data.status == ST_ABNORMAL) |->
      ((out_data.status == ST_MISMATCH) && (out_data.mismatch_total != '0)) ||
      ((out_data.status == ST_ABNORMAL) && (out_data.abnormal_total != '0)))
    else $error("Counter still zero on a counted result.");

endmodule

bind traceroute_reply_classifier_core trc_checker u_trc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);
